// ----- hw/rtl/cas_pkg.sv -----
// ----------------------------------------------------------------------------
// Credit admission scheduler package
// Shared types, constants and codes for the scheduler core.
// ----------------------------------------------------------------------------
package cas_pkg;

  localparam int QueuesDefault    = 4;
  localparam int FifoDepthDefault = 8;

  localparam logic [23:0] CreditPerTickReset  = 24'd400000;
  localparam logic [2:0]  QueuesInUseReset    = 3'd1;
  localparam logic [7:0]  SendQueueLimitReset = 8'd64;
  localparam logic [3:0]  FifoLimitReset      = 4'd8;

  typedef enum logic [1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_PASS     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_CREDIT_PER_TICK  = 2'd0,
    REG_QUEUES_IN_USE    = 2'd1,
    REG_SEND_QUEUE_LIMIT = 2'd2,
    REG_FIFO_LIMIT       = 2'd3
  } reg_index_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FIFO_FULL = 2'd1;
  localparam logic [1:0] STATUS_OVER_DONE = 2'd2;

  localparam logic KIND_ADMIT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_READ,
    ST_CHECK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  queue_sel;
    logic [31:0] req_length;
    logic [15:0] req_tag;
    logic [7:0]  done_count;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  out_queue;
    logic [31:0] out_length;
    logic [15:0] out_tag;
    logic [1:0]  status;
    logic [31:0] credit_left;
    logic        last;
  } out_item_t;

endpackage

// ----- hw/rtl/credit_admission_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// Credit admission scheduler core
// Enqueue, tick and completion run IDLE, EXEC, OUT; the input is ready again
// once the result transfer returns to IDLE. A pass goes from EXEC to SCAN,
// which skips each queue that cannot be tried; else READ and CHECK test its
// head request and admit it through OUT or, if it exceeds the credit, go on
// to the next queue. A closing status ends the pass. One item at a time; the
// store read port and the single credit compare set the pace. Synchronous
// reset clears pointers, counts, occupancy and credit, but not the store.
// ----------------------------------------------------------------------------
module credit_admission_scheduler_core import cas_pkg::*; #(
  parameter int QUEUES     = QueuesDefault,
  parameter int FIFO_DEPTH = FifoDepthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int AW = QW + PW;

  logic [23:0] credit_per_tick;
  logic [2:0]  queues_in_use;
  logic [7:0]  send_queue_limit;
  logic [3:0]  fifo_limit;

  logic [PW-1:0] fifo_head [QUEUES];
  logic [PW-1:0] fifo_tail [QUEUES];
  logic [CW-1:0] fifo_count [QUEUES];
  logic [7:0]    send_occupancy [QUEUES];
  logic [31:0]   credit;

  state_t   state, state_next;
  in_item_t item;
  logic [QW-1:0] qi;
  logic [4:0]    nq;
  out_item_t     obuf;

  logic          st_wr;
  logic [AW-1:0] st_rd_addr;
  logic [47:0]   st_rd;

  logic       q_ok;
  logic [7:0] cap;
  logic [QW-1:0] sel_q;
  logic       can_try;
  logic [32:0] tick_sum;
  logic [31:0] tick_sat;
  logic [4:0]  qi_ext;
  logic        scan_end;
  logic        last_q;
  logic        too_long;
  logic [1:0]  exec_status;
  logic [1:0]  exec_queue;
  logic [31:0] exec_credit;

  assign q_ok  = {30'd0, item.queue_sel} < 32'(QUEUES);
  assign sel_q = QW'(item.queue_sel);
  assign cap   = ({4'd0, fifo_limit} < 8'(FIFO_DEPTH)) ? {4'd0, fifo_limit}
                                                       : 8'(FIFO_DEPTH);
  assign nq    = ({2'd0, queues_in_use} < 5'(QUEUES)) ? {2'd0, queues_in_use}
                                                     : 5'(QUEUES);
  assign can_try = fifo_count[qi] != '0 && credit != 32'd0 &&
                   send_occupancy[qi] < send_queue_limit;
  assign tick_sum = {1'b0, credit} + {9'd0, credit_per_tick};
  assign tick_sat = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];

  assign qi_ext   = {{(5-QW){1'b0}}, qi};
  assign scan_end = qi_ext >= nq;
  assign last_q   = qi_ext + 5'd1 >= nq;
  assign too_long = st_rd[47:16] > credit;

  assign st_wr = state == ST_EXEC && item.cmd == CMD_ENQUEUE && q_ok &&
                 8'(fifo_count[sel_q]) < cap;
  assign st_rd_addr = {qi, fifo_head[qi]};

  cas_store #(.AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (st_wr),
    .wr_addr ({sel_q, fifo_tail[sel_q]}),
    .wr_data ({item.req_length, item.req_tag}),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_per_tick  <= CreditPerTickReset;
      queues_in_use    <= QueuesInUseReset;
      send_queue_limit <= SendQueueLimitReset;
      fifo_limit       <= FifoLimitReset;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_CREDIT_PER_TICK:  credit_per_tick  <= cfg_wdata;
        REG_QUEUES_IN_USE:    queues_in_use    <= cfg_wdata[2:0];
        REG_SEND_QUEUE_LIMIT: send_queue_limit <= cfg_wdata[7:0];
        REG_FIFO_LIMIT:       fifo_limit       <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    exec_status = STATUS_OK;
    exec_queue  = item.queue_sel;
    exec_credit = credit;
    unique case (cmd_t'(item.cmd))
      CMD_ENQUEUE: begin
        if (!st_wr) exec_status = STATUS_FIFO_FULL;
      end
      CMD_TICK: begin
        exec_queue  = '0;
        exec_credit = tick_sat;
      end
      CMD_COMPLETE: begin
        if (q_ok && item.done_count > send_occupancy[sel_q]) begin
          exec_status = STATUS_OVER_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_EXEC;
      ST_EXEC:  state_next = (item.cmd == CMD_PASS) ? ST_SCAN : ST_OUT;
      ST_SCAN: begin
        if (scan_end || (!can_try && last_q)) state_next = ST_OUT;
        else if (can_try) state_next = ST_READ;
        else state_next = ST_SCAN;
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = (too_long && !last_q) ? ST_SCAN : ST_OUT;
      ST_OUT: begin
        if (out_ready) state_next = obuf.last ? ST_IDLE : ST_SCAN;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == ST_IDLE;
    out_valid = state == ST_OUT;
    out_data  = obuf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      credit <= '0;
      qi     <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        fifo_head[i]      <= '0;
        fifo_tail[i]      <= '0;
        fifo_count[i]     <= '0;
        send_occupancy[i] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item <= in_data;
          end
        end
        ST_EXEC: begin
          obuf <= '{kind: KIND_STATUS, out_queue: exec_queue, out_length: '0,
                    out_tag: '0, status: exec_status, credit_left: exec_credit,
                    last: 1'b1};
          unique case (cmd_t'(item.cmd))
            CMD_ENQUEUE: begin
              if (st_wr) begin
                fifo_tail[sel_q] <= (fifo_tail[sel_q] == PW'(FIFO_DEPTH - 1)) ? '0
                                    : fifo_tail[sel_q] + 1'b1;
                fifo_count[sel_q] <= fifo_count[sel_q] + 1'b1;
              end
            end
            CMD_TICK: begin
              credit <= tick_sat;
            end
            CMD_COMPLETE: begin
              if (q_ok) begin
                if (item.done_count > send_occupancy[sel_q]) begin
                  send_occupancy[sel_q] <= '0;
                end else begin
                  send_occupancy[sel_q] <= send_occupancy[sel_q] - item.done_count;
                end
              end
            end
            CMD_PASS: begin
              qi <= '0;
            end
            default: ;
          endcase
        end
        ST_SCAN: begin
          if (scan_end || (!can_try && last_q)) begin
            obuf <= '{kind: KIND_STATUS, out_queue: '0, out_length: '0, out_tag: '0,
                      status: STATUS_OK, credit_left: credit, last: 1'b1};
          end else if (!can_try) begin
            qi <= qi + 1'b1;
          end
        end
        ST_READ: ;
        ST_CHECK: begin
          if (too_long) begin
            if (last_q) begin
              obuf <= '{kind: KIND_STATUS, out_queue: '0, out_length: '0,
                        out_tag: '0, status: STATUS_OK, credit_left: credit,
                        last: 1'b1};
            end else begin
              qi <= qi + 1'b1;
            end
          end else begin
            credit <= credit - st_rd[47:16];
            send_occupancy[qi] <= send_occupancy[qi] + 8'd1;
            fifo_head[qi] <= (fifo_head[qi] == PW'(FIFO_DEPTH - 1)) ? '0
                             : fifo_head[qi] + 1'b1;
            fifo_count[qi] <= fifo_count[qi] - 1'b1;
            obuf <= '{kind: KIND_ADMIT, out_queue: 2'(qi), out_length: st_rd[47:16],
                      out_tag: st_rd[15:0], status: STATUS_OK,
                      credit_left: credit - st_rd[47:16], last: 1'b0};
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_admit_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_ADMIT |-> !out_data.last)
    else $error("admitted item marked last");
  a_credit_drop: assert property (@(posedge clk) disable iff (rst)
    $past(state) == ST_CHECK && out_valid && out_data.kind == KIND_ADMIT
    |-> credit == out_data.credit_left) else $error("credit mismatch");

endmodule

// ----- hw/rtl/cas_store.sv -----
// ----------------------------------------------------------------------------
// Request store
// One memory holding the length and tag of every waiting request.
// ----------------------------------------------------------------------------
module cas_store import cas_pkg::*; #(
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [47:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [47:0]   rd_data
);

  logic [47:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- tb/credit_admission_scheduler_core_tb.sv -----
// ----------------------------------------------------------------------------
// Credit admission scheduler core testbench
// Drives enqueue, tick, completion and admission pass items through the
// valid/ready input with bursty gaps, stalls the output on its own pattern,
// and checks every result transfer field by field against a built-in model
// of the queues, occupancy and shared credit. Registers are rewritten between
// phases while the block is idle, including the extremes of each register.
// ----------------------------------------------------------------------------
module credit_admission_scheduler_core_tb;
  import cas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NQ = 4;
  localparam int DEPTH = 8;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_CREDIT_PER_TICK;
  logic [23:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  credit_admission_scheduler_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  logic [31:0] m_per_tick;
  logic [2:0] m_queues;
  logic [7:0] m_sq_limit;
  logic [3:0] m_fifo_limit;
  logic [31:0] m_len [NQ][DEPTH];
  logic [15:0] m_tag [NQ][DEPTH];
  int unsigned m_head [NQ];
  int unsigned m_tail [NQ];
  int unsigned m_count [NQ];
  int unsigned m_occ [NQ];
  logic [31:0] m_credit;

  out_item_t expected_results[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int admitted = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit long_hold = 1'b0;
  bit finished = 1'b0;

  function automatic out_item_t make_status(logic [1:0] q, logic [1:0] st);
    out_item_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.out_queue = q;
    r.status = st;
    r.credit_left = m_credit;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_item(in_item_t it);
    out_item_t r;
    int unsigned cap;
    int unsigned nq;
    int unsigned h;
    logic [1:0] st;
    logic [32:0] sum;
    cap = (m_fifo_limit < DEPTH) ? m_fifo_limit : DEPTH;
    case (cmd_t'(it.cmd))
      CMD_ENQUEUE: begin
        st = STATUS_FIFO_FULL;
        if (m_count[it.queue_sel] < cap) begin
          m_len[it.queue_sel][m_tail[it.queue_sel]] = it.req_length;
          m_tag[it.queue_sel][m_tail[it.queue_sel]] = it.req_tag;
          m_tail[it.queue_sel] = (m_tail[it.queue_sel] + 1) % DEPTH;
          m_count[it.queue_sel]++;
          st = STATUS_OK;
        end
        expected_results.push_back(make_status(it.queue_sel, st));
      end
      CMD_TICK: begin
        sum = {1'b0, m_credit} + {1'b0, m_per_tick};
        m_credit = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        expected_results.push_back(make_status(2'd0, STATUS_OK));
      end
      CMD_COMPLETE: begin
        st = STATUS_OK;
        if (it.done_count > m_occ[it.queue_sel]) begin
          m_occ[it.queue_sel] = 0;
          st = STATUS_OVER_DONE;
        end else begin
          m_occ[it.queue_sel] -= it.done_count;
        end
        expected_results.push_back(make_status(it.queue_sel, st));
      end
      default: begin
        nq = (m_queues < NQ) ? m_queues : NQ;
        for (int q = 0; q < nq; q++) begin
          while (m_count[q] > 0 && m_credit != 0 && m_occ[q] < m_sq_limit) begin
            h = m_head[q];
            if (m_len[q][h] > m_credit) break;
            m_credit -= m_len[q][h];
            m_occ[q]++;
            m_head[q] = (h + 1) % DEPTH;
            m_count[q]--;
            r = '0;
            r.kind = KIND_ADMIT;
            r.out_queue = q[1:0];
            r.out_length = m_len[q][h];
            r.out_tag = m_tag[q][h];
            r.status = STATUS_OK;
            r.credit_left = m_credit;
            r.last = 1'b0;
            expected_results.push_back(r);
          end
        end
        expected_results.push_back(make_status(2'd0, STATUS_OK));
      end
    endcase
  endtask

  task automatic send_item(in_item_t it);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
    sent++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CREDIT_PER_TICK: m_per_tick = {8'd0, val};
      REG_QUEUES_IN_USE: m_queues = val[2:0];
      REG_SEND_QUEUE_LIMIT: m_sq_limit = val[7:0];
      default: m_fifo_limit = val[3:0];
    endcase
    @(posedge clk);
  endtask

  function automatic in_item_t make_item(cmd_t c, logic [1:0] q, logic [31:0] len,
                                         logic [15:0] tag, logic [7:0] done);
    in_item_t it;
    it.cmd = c;
    it.queue_sel = q;
    it.req_length = len;
    it.req_tag = tag;
    it.done_count = done;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int unsigned pick;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: len = $urandom();
      1: len = $urandom_range(0, 4);
      default: len = $urandom_range(0, 300000);
    endcase
    if (pick < 45) return make_item(CMD_ENQUEUE, 2'($urandom()), len, 16'($urandom()),
                                    8'($urandom()));
    if (pick < 60) return make_item(CMD_TICK, 2'($urandom()), $urandom(),
                                    16'($urandom()), 8'($urandom()));
    if (pick < 75) return make_item(CMD_COMPLETE, 2'($urandom()), $urandom(),
                                    16'($urandom()),
                                    ($urandom_range(0, 3) == 0) ? 8'($urandom()) :
                                    8'($urandom_range(0, 3)));
    return make_item(CMD_PASS, 2'($urandom()), $urandom(), 16'($urandom()),
                     8'($urandom()));
  endfunction

  task automatic test_directed();
    write_reg(REG_CREDIT_PER_TICK, 24'hFFFFFF);
    write_reg(REG_QUEUES_IN_USE, 24'd4);
    send_item(make_item(CMD_PASS, 2'd0, 32'd0, 16'd0, 8'd0));
    send_item(make_item(CMD_ENQUEUE, 2'd0, 32'd0, 16'hFFFF, 8'hFF));
    send_item(make_item(CMD_ENQUEUE, 2'd1, 32'hFFFF_FFFF, 16'h0000, 8'h00));
    send_item(make_item(CMD_ENQUEUE, 2'd3, 32'd100, 16'hA5A5, 8'd0));
    send_item(make_item(CMD_PASS, 2'd3, 32'd0, 16'd0, 8'd0));
    for (int i = 0; i < 3; i++) send_item(make_item(CMD_TICK, 2'd0, 32'd0, 16'd0, 8'd0));
    send_item(make_item(CMD_PASS, 2'd0, 32'd0, 16'd0, 8'd0));
    for (int i = 0; i < 20; i++) send_item(make_item(CMD_TICK, 2'd2, 32'd0, 16'd0, 8'd0));
    send_item(make_item(CMD_PASS, 2'd0, 32'd0, 16'd0, 8'd0));
    send_item(make_item(CMD_COMPLETE, 2'd0, 32'd0, 16'd0, 8'd255));
    send_item(make_item(CMD_COMPLETE, 2'd3, 32'd0, 16'd0, 8'd0));
    send_item(make_item(CMD_COMPLETE, 2'd1, 32'd0, 16'd0, 8'd1));
    for (int i = 0; i < 9; i++)
      send_item(make_item(CMD_ENQUEUE, 2'd2, 32'd1, 16'(i), 8'd0));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_FIFO_LIMIT, 24'd0);
    send_item(make_item(CMD_ENQUEUE, 2'd1, 32'd5, 16'd1, 8'd0));
    wait_drained();
    write_reg(REG_FIFO_LIMIT, 24'd15);
    write_reg(REG_QUEUES_IN_USE, 24'd7);
    write_reg(REG_SEND_QUEUE_LIMIT, 24'd0);
    send_item(make_item(CMD_ENQUEUE, 2'd1, 32'd5, 16'd2, 8'd0));
    send_item(make_item(CMD_PASS, 2'd0, 32'd0, 16'd0, 8'd0));
    wait_drained();
    write_reg(REG_SEND_QUEUE_LIMIT, 24'd1);
    write_reg(REG_QUEUES_IN_USE, 24'd0);
    send_item(make_item(CMD_PASS, 2'd0, 32'd0, 16'd0, 8'd0));
    wait_drained();
    write_reg(REG_QUEUES_IN_USE, 24'd2);
    write_reg(REG_CREDIT_PER_TICK, 24'd0);
    send_item(make_item(CMD_TICK, 2'd0, 32'd0, 16'd0, 8'd0));
    send_item(make_item(CMD_PASS, 2'd0, 32'd0, 16'd0, 8'd0));
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++)
      send_item(make_item(CMD_ENQUEUE, i[1:0], $urandom_range(0, 50), 16'($urandom()),
                          8'd0));
    wait (!hold_off);
    wait_drained();
  endtask

  task automatic test_random(int n, logic [23:0] tick, logic [2:0] qs,
                             logic [7:0] lim, logic [3:0] fl);
    write_reg(REG_CREDIT_PER_TICK, tick);
    write_reg(REG_QUEUES_IN_USE, {21'd0, qs});
    write_reg(REG_SEND_QUEUE_LIMIT, {16'd0, lim});
    write_reg(REG_FIFO_LIMIT, {20'd0, fl});
    for (int i = 0; i < n; i++) send_item(random_item());
    wait_drained();
  endtask

  initial begin
    long_hold = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !long_hold) begin
        long_hold = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
        long_hold = 1'b0;
      end else if (($urandom_range(0, 63) < 8) ? 1'b1 : 1'b0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0) || (sent % 50 > 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      out_item_t e;
      received++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.kind == KIND_ADMIT) admitted++;
        if (out_data.kind !== e.kind) begin
          $error("kind: expected %0d, actual %0d", e.kind, out_data.kind); errors++;
        end
        if (out_data.out_queue !== e.out_queue) begin
          $error("out_queue: expected %0d, actual %0d", e.out_queue, out_data.out_queue);
          errors++;
        end
        if (out_data.out_length !== e.out_length) begin
          $error("out_length: expected %0d, actual %0d", e.out_length, out_data.out_length);
          errors++;
        end
        if (out_data.out_tag !== e.out_tag) begin
          $error("out_tag: expected %0d, actual %0d", e.out_tag, out_data.out_tag); errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_data.status); errors++;
        end
        if (out_data.credit_left !== e.credit_left) begin
          $error("credit_left: expected %0d, actual %0d", e.credit_left,
                 out_data.credit_left);
          errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, out_data.last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || finished || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** credit_admission_scheduler_core: FAILED **");
      $finish;
    end
  end

  initial begin
    m_per_tick = {8'd0, CreditPerTickReset};
    m_queues = QueuesInUseReset;
    m_sq_limit = SendQueueLimitReset;
    m_fifo_limit = FifoLimitReset;
    m_credit = '0;
    for (int q = 0; q < NQ; q++) begin
      m_head[q] = 0; m_tail[q] = 0; m_count[q] = 0; m_occ[q] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random(40, 24'd200000, 3'd4, 8'd4, 4'd8);
    test_random(40, 24'd50000, 3'd3, 8'd255, 4'd3);
    test_random(40, 24'd1000, 3'd4, 8'd16, 4'd1);
    wait_drained();
    finished = 1'b1;
    $display("Covered %0d input items and %0d results, %0d of them admissions,",
             sent, received, admitted);
    $display("over fifo, send-queue, scan and credit register extremes.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** credit_admission_scheduler_core: PASSED **");
    end else begin
      $display("** credit_admission_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule
